// ===== hdl/ssi_pkg.sv =====
// Shared constants and types for the sorted stream intersection block.
package ssi_pkg;

    localparam int PENDING_DEPTH = 16;
    localparam int TERM_WIDTH    = 64;
    localparam int PORT_TERM_W   = 64;
    localparam int PTR_W         = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);
    localparam int SUM_W         = CNT_W + 1;

    typedef logic [TERM_WIDTH-1:0] t_term;
    typedef logic [PTR_W-1:0]      t_ptr;
    typedef logic [CNT_W-1:0]      t_cnt;

    typedef enum logic [2:0] {
        ACT_FIRST_ELEM  = 3'd0,
        ACT_SECOND_ELEM = 3'd1,
        ACT_FIRST_END   = 3'd2,
        ACT_SECOND_END  = 3'd3,
        ACT_RESTART     = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        t_term value;
        logic  is_match;
        logic  done_res;
        logic  overflow;
    } t_result;

endpackage

// ===== hdl/sorted_stream_intersection.sv =====
// Sorted merge intersection of two tagged, interleaved ascending columns.
// An overflow or a finishing end mark goes from accept straight to EMIT; an element of one
// column that finds waiting elements of the other passes READ then CMP for each waiting
// element inspected, then goes to EMIT on a match or a finishing drain, else back to IDLE.
// A request that neither compares nor posts is done at accept. Posting waits while the
// output register is full. A new request is accepted only in IDLE (o_ready).
// Reset (i_rst_n low, synchronous) clears all control state; memory contents stay undefined.
module sorted_stream_intersection (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [63:0] i_term,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_match_value,
    output logic        o_is_match,
    output logic        o_done_res,
    output logic        o_overflow
);

    // Pending store: FIFO of elements of one column that still wait for the
    // other column. Single write port, single registered read port at the head.
    ssi_pkg::t_term mem [ssi_pkg::PENDING_DEPTH];
    ssi_pkg::t_term r_rd_data;
    logic           mem_we;
    ssi_pkg::t_ptr  mem_wa;
    ssi_pkg::t_term mem_wd;

    // control state
    ssi_pkg::t_state r_state, n_state;
    logic            r_side, n_side;           // column of waiting elements
    ssi_pkg::t_ptr   r_head, n_head;
    ssi_pkg::t_cnt   r_count, n_count;
    logic            r_first_end, n_first_end;
    logic            r_second_end, n_second_end;
    logic            r_finished, n_finished;

    // request being worked on
    logic            r_req_side, n_req_side;
    ssi_pkg::t_term  r_term, n_term;
    ssi_pkg::t_result r_res, n_res;

    // output register
    logic             r_o_valid, n_o_valid;
    ssi_pkg::t_result r_out, n_out;

    // helpers
    ssi_pkg::t_term   in_term;
    ssi_pkg::t_action in_act;
    logic [ssi_pkg::SUM_W-1:0] push_sum;
    ssi_pkg::t_ptr    push_idx;
    ssi_pkg::t_ptr    head_inc;
    ssi_pkg::t_cnt    count_dec;
    logic             other_ended;
    logic             req_ended;

    assign in_term = i_term[ssi_pkg::TERM_WIDTH-1:0];
    assign in_act  = ssi_pkg::t_action'(i_action);

    // tail slot: head + count, wrapped once (count is below depth when pushing)
    assign push_sum = ssi_pkg::SUM_W'(r_head) + ssi_pkg::SUM_W'(r_count);
    assign push_idx = (push_sum >= ssi_pkg::SUM_W'(ssi_pkg::PENDING_DEPTH))
                    ? ssi_pkg::PTR_W'(push_sum - ssi_pkg::SUM_W'(ssi_pkg::PENDING_DEPTH))
                    : ssi_pkg::PTR_W'(push_sum);
    assign head_inc = (r_head == ssi_pkg::PTR_W'(ssi_pkg::PENDING_DEPTH - 1))
                    ? '0 : r_head + ssi_pkg::PTR_W'(1);
    assign count_dec = r_count - ssi_pkg::CNT_W'(1);

    // in the compare phase the waiting elements belong to the other column
    assign other_ended = r_req_side ? r_first_end : r_second_end;
    assign req_ended   = r_req_side ? r_second_end : r_first_end;

    assign o_ready       = (r_state == ssi_pkg::ST_IDLE);
    assign o_valid       = r_o_valid;
    assign o_match_value = ssi_pkg::PORT_TERM_W'(r_out.value);
    assign o_is_match    = r_out.is_match;
    assign o_done_res    = r_out.done_res;
    assign o_overflow    = r_out.overflow;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ssi_pkg::ST_IDLE;
            r_side       <= 1'b0;
            r_head       <= '0;
            r_count      <= '0;
            r_first_end  <= 1'b0;
            r_second_end <= 1'b0;
            r_finished   <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_side       <= n_side;
            r_head       <= n_head;
            r_count      <= n_count;
            r_first_end  <= n_first_end;
            r_second_end <= n_second_end;
            r_finished   <= n_finished;
            r_o_valid    <= n_o_valid;
        end
        r_req_side <= n_req_side;
        r_term     <= n_term;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    always_comb begin
        n_state      = r_state;
        n_side       = r_side;
        n_head       = r_head;
        n_count      = r_count;
        n_first_end  = r_first_end;
        n_second_end = r_second_end;
        n_finished   = r_finished;
        n_req_side   = r_req_side;
        n_term       = r_term;
        n_res        = r_res;
        n_o_valid    = r_o_valid;
        n_out        = r_out;
        mem_we       = 1'b0;
        mem_wa       = push_idx;
        mem_wd       = in_term;

        // output register drains independently of the request side
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            ssi_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_term     = in_term;
                    n_req_side = i_action[0];
                    n_res      = '0;
                    if (in_act == ssi_pkg::ACT_RESTART) begin
                        n_side       = 1'b0;
                        n_head       = '0;
                        n_count      = '0;
                        n_first_end  = 1'b0;
                        n_second_end = 1'b0;
                        n_finished   = 1'b0;
                    end else if (!r_finished) begin
                        case (in_act)
                            ssi_pkg::ACT_FIRST_ELEM,
                            ssi_pkg::ACT_SECOND_ELEM: begin
                                if (!(i_action[0] ? r_second_end : r_first_end)) begin
                                    if (r_count != '0 && r_side != i_action[0]) begin
                                        // waiting elements of the other column: compare
                                        n_state = ssi_pkg::ST_READ;
                                    end else if (r_count ==
                                                 ssi_pkg::CNT_W'(ssi_pkg::PENDING_DEPTH)) begin
                                        n_res.overflow = 1'b1;
                                        n_state        = ssi_pkg::ST_EMIT;
                                    end else if (r_count == '0) begin
                                        n_side  = i_action[0];
                                        n_head  = '0;
                                        n_count = ssi_pkg::CNT_W'(1);
                                        mem_we  = 1'b1;
                                        mem_wa  = '0;
                                    end else begin
                                        n_count = r_count + ssi_pkg::CNT_W'(1);
                                        mem_we  = 1'b1;
                                    end
                                end
                            end
                            ssi_pkg::ACT_FIRST_END,
                            ssi_pkg::ACT_SECOND_END: begin
                                if (!(i_action[0] ? r_second_end : r_first_end)) begin
                                    if (i_action[0]) begin
                                        n_second_end = 1'b1;
                                    end else begin
                                        n_first_end = 1'b1;
                                    end
                                    // nothing of this column waits: finished
                                    if (r_count == '0 || r_side != i_action[0]) begin
                                        n_finished     = 1'b1;
                                        n_count        = '0;
                                        n_head         = '0;
                                        n_res.done_res = 1'b1;
                                        n_state        = ssi_pkg::ST_EMIT;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end

            ssi_pkg::ST_READ: begin
                // head entry is read at this edge
                n_state = ssi_pkg::ST_CMP;
            end

            ssi_pkg::ST_CMP: begin
                if (r_rd_data > r_term) begin
                    // incoming element is smaller than the head: drop it
                    n_state = ssi_pkg::ST_IDLE;
                end else begin
                    n_head  = head_inc;
                    n_count = count_dec;
                    if (r_rd_data == r_term) begin
                        n_res.value    = r_term;
                        n_res.is_match = 1'b1;
                        if (count_dec == '0 && other_ended) begin
                            n_finished     = 1'b1;
                            n_count        = '0;
                            n_head         = '0;
                            n_res.done_res = 1'b1;
                        end
                        n_state = ssi_pkg::ST_EMIT;
                    end else if (count_dec == '0 && other_ended) begin
                        // drained an ended column: the element is discarded
                        n_finished     = 1'b1;
                        n_head         = '0;
                        n_res.done_res = 1'b1;
                        n_state        = ssi_pkg::ST_EMIT;
                    end else if (count_dec == '0) begin
                        // store empty: the element starts waiting on its own column
                        n_side  = r_req_side;
                        n_head  = '0;
                        n_count = ssi_pkg::CNT_W'(1);
                        mem_we  = 1'b1;
                        mem_wa  = '0;
                        mem_wd  = r_term;
                        n_state = ssi_pkg::ST_IDLE;
                    end else begin
                        n_state = ssi_pkg::ST_READ;
                    end
                end
                // element of an ended column never reaches here
                if (req_ended) begin
                    n_state = ssi_pkg::ST_IDLE;
                end
            end

            ssi_pkg::ST_EMIT: begin
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_out     = r_res;
                    n_state   = ssi_pkg::ST_IDLE;
                end
            end

            default: n_state = ssi_pkg::ST_IDLE;
        endcase
    end

endmodule
